// File: design/lee_pkg.sv
// Package for the line editor: byte codes, message bytes and the beat type.
// No dependencies; used by lee_ctrl and line_editor_echo.
`timescale 1ns / 1ps
`default_nettype none

package lee_pkg;

    localparam logic [7:0] CODE_BS    = 8'd8;
    localparam logic [7:0] CODE_LF    = 8'd10;
    localparam logic [7:0] CODE_CR    = 8'd13;
    localparam logic [7:0] CODE_SPACE = 8'd32;
    localparam logic [7:0] CODE_TILDE = 8'd126;
    localparam logic [7:0] CODE_DEL   = 8'd127;
    localparam logic [7:0] CODE_QUOTE = 8'd39;

    localparam logic [3:0] HEAD_LAST = 4'd12;
    localparam logic [3:0] TAIL_LAST = 4'd1;
    localparam logic [3:0] ERASE_MID = 4'd1;
    localparam logic [3:0] ERASE_LAST = 4'd2;

    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       last;
    } beat_t;

    function automatic logic [7:0] head_byte(input logic [3:0] idx);
        logic [7:0] b;
        begin
            case (idx)
                4'd0:    b = CODE_LF;
                4'd1:    b = 8'h59;
                4'd2:    b = 8'h6f;
                4'd3:    b = 8'h75;
                4'd4:    b = CODE_SPACE;
                4'd5:    b = 8'h74;
                4'd6:    b = 8'h79;
                4'd7:    b = 8'h70;
                4'd8:    b = 8'h65;
                4'd9:    b = 8'h64;
                4'd10:   b = 8'h3a;
                4'd11:   b = CODE_SPACE;
                4'd12:   b = CODE_QUOTE;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    function automatic logic [7:0] tail_byte(input logic [3:0] idx);
        logic [7:0] b;
        begin
            b = (idx == 4'd0) ? CODE_QUOTE : CODE_LF;
            return b;
        end
    endfunction

endpackage

`default_nettype wire

// File: design/lee_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/lee_ctrl.sv
// Sequencer of the line editor: decodes a received byte, keeps the fill count
// and steps out the echo beats one at a time. Depends on lee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lee_ctrl
    import lee_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [7:0]                       rx_byte,
    input  wire logic                             slot_free,
    output beat_t                                 beat,
    output logic                                  ram_we,
    output logic      [$clog2(LINE_CAPACITY)-1:0] ram_waddr,
    output logic      [7:0]                       ram_wdata,
    output logic      [$clog2(LINE_CAPACITY)-1:0] ram_raddr,
    input  wire logic [7:0]                       ram_rdata
);

    localparam int FW = $clog2(LINE_CAPACITY);
    localparam logic [FW-1:0] FULL_LEVEL = FW'(LINE_CAPACITY - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ERASE = 3'd1;
    localparam logic [2:0] ST_PRINT = 3'd2;
    localparam logic [2:0] ST_HEAD  = 3'd3;
    localparam logic [2:0] ST_BODY  = 3'd4;
    localparam logic [2:0] ST_TAIL  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [FW-1:0] bidx_reg, bidx_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    char_reg, char_next;
    logic [FW-1:0] last_idx;
    logic          accept;
    logic          is_back, is_print, is_enter, not_empty, full;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_back   = (rx_byte == CODE_BS) || (rx_byte == CODE_DEL);
    assign is_enter  = (rx_byte == CODE_LF) || (rx_byte == CODE_CR);
    assign is_print  = (rx_byte >= CODE_SPACE) && (rx_byte <= CODE_TILDE);
    assign not_empty = (fill_reg != '0);
    assign full      = (fill_reg >= FULL_LEVEL);
    assign last_idx  = fill_reg - FW'(1);

    assign ram_we    = accept && is_print && !(is_back && not_empty) && !full;
    assign ram_waddr = fill_reg;
    assign ram_wdata = rx_byte;
    assign ram_raddr = bidx_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bidx_next  = bidx_reg;
        fill_next  = fill_reg;
        char_next  = char_reg;
        beat       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    char_next = rx_byte;
                    cnt_next  = '0;
                    bidx_next = '0;
                    if (is_back && not_empty)
                    begin
                        fill_next  = fill_reg - FW'(1);
                        state_next = ST_ERASE;
                    end
                    else if (is_print && !full)
                    begin
                        fill_next  = fill_reg + FW'(1);
                        state_next = ST_PRINT;
                    end
                    else if ((is_enter && not_empty) || full)
                    begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_ERASE:
            begin
                if (slot_free)
                begin
                    beat.push = 1'b1;
                    beat.data = (cnt_reg == ERASE_MID) ? CODE_SPACE : CODE_BS;
                    beat.last = (cnt_reg == ERASE_LAST);
                    cnt_next  = cnt_reg + 4'd1;
                    if (cnt_reg == ERASE_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PRINT:
            begin
                if (slot_free)
                begin
                    beat.push  = 1'b1;
                    beat.data  = char_reg;
                    beat.last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_HEAD:
            begin
                if (slot_free)
                begin
                    beat.push = 1'b1;
                    beat.data = head_byte(cnt_reg);
                    cnt_next  = cnt_reg + 4'd1;
                    if (cnt_reg == HEAD_LAST)
                    begin
                        cnt_next   = '0;
                        state_next = ST_BODY;
                    end
                end
            end
            ST_BODY:
            begin
                if (slot_free)
                begin
                    beat.push = 1'b1;
                    beat.data = ram_rdata;
                    bidx_next = bidx_reg + FW'(1);
                    if (bidx_reg == last_idx)
                    begin
                        bidx_next  = '0;
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_TAIL:
            begin
                if (slot_free)
                begin
                    beat.push = 1'b1;
                    beat.data = tail_byte(cnt_reg);
                    beat.last = (cnt_reg == TAIL_LAST);
                    cnt_next  = cnt_reg + 4'd1;
                    if (cnt_reg == TAIL_LAST)
                    begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            bidx_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bidx_reg  <= bidx_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

`ifndef SYNTHESIS
    a_push_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        beat.push |-> slot_free)
        else $error("beat pushed into occupied output slot");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_LEVEL)
        else $error("fill count beyond line capacity");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAIL && beat.push && beat.last) |=> (fill_reg == '0))
        else $error("line not cleared after flush");

    a_busy_during_run: assert property (@(posedge clk) disable iff (!rst_n)
        (beat.push && !beat.last) |=> !in_ready)
        else $error("input taken before run finished");
`endif

endmodule

`default_nettype wire

// File: design/line_editor_echo.sv
// Top level of the terminal line editor with echo: sequencer, line store RAM
// and output register. Depends on lee_pkg, lee_ctrl and lee_ram.
//
// One received byte is taken while the block is idle; in_ready then stays low
// until every echo beat of that byte has been handed to the output register.
// The sequencer emits at most one beat per cycle. The line store is read one
// character per cycle through its registered read port while the output slot
// is free. No clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none

module line_editor_echo
    import lee_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] echo_byte,
    output logic            last_of_run
);

    localparam int AW = $clog2(LINE_CAPACITY);

    beat_t         beat;
    logic          slot_free;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    echo_reg, echo_next;
    logic          last_reg, last_next;

    assign slot_free = !out_valid_reg || out_ready;

    lee_ctrl #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .slot_free (slot_free),
        .beat      (beat),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    lee_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAPACITY)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        echo_next      = echo_reg;
        last_next      = last_reg;
        if (beat.push)
        begin
            out_valid_next = 1'b1;
            echo_next      = beat.data;
            last_next      = beat.last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // hold the beat until the far side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        echo_reg <= echo_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign echo_byte   = echo_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire
